>>> hw/rtl/cfla_pkg.sv
// Shared types and constants for the chunk free-list allocator.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package cfla_pkg;

  // Largest number of chunks the design may hand out.
  localparam int MAX_CHUNKS  = 4096;
  // Chunk indices are 12 bits wide, so the usable index space is capped at 4096.
  localparam int INDEX_SPACE = (MAX_CHUNKS < 4096) ? MAX_CHUNKS : 4096;
  localparam int ADDR_W      = $clog2(INDEX_SPACE);

  // Field widths of the channels.
  localparam int OP_W     = 2;
  localparam int IDX_W    = 12;
  localparam int CNT_W    = 13;
  localparam int BYTES_W  = 32;
  localparam int TOTAL_W  = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Operation codes of a request.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_PER_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES      = 2'd2;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]   RST_CHUNKS_PER_BLOCK = 13'd64;
  localparam logic [CNT_W-1:0]   RST_BLOCK_LIMIT      = 13'd64;
  localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES      = 32'd4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and start the link read
    logic commit;  // update the state and register the result
  } cfla_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // the result register can take a new result this cycle
  } cfla_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/cfla_ifs.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
// Depends on cfla_pkg for field widths.
`default_nettype none

interface cfla_req_if;
  import cfla_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   chunk_index;
  modport source (output valid, output operation, output chunk_index, input ready);
  modport sink   (input valid, input operation, input chunk_index, output ready);
endinterface

interface cfla_rsp_if;
  import cfla_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [IDX_W-1:0]   chunk_given;
  logic [CNT_W-1:0]   free_count;
  logic [CNT_W-1:0]   used_count;
  logic [TOTAL_W-1:0] total_bytes;
  modport source (output valid, output ok, output chunk_given, output free_count,
                  output used_count, output total_bytes, input ready);
  modport sink   (input valid, input ok, input chunk_given, input free_count,
                  input used_count, input total_bytes, output ready);
endinterface

interface cfla_cfg_if;
  import cfla_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cfla_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module cfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/cfla_ctrl.sv
// Controller of the allocator: takes a request, then commits it once the result slot is free.
// Depends on cfla_pkg for the command and status types.
`default_nettype none

module cfla_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cfla_pkg::cfla_sts_t  sts,
  output cfla_pkg::cfla_cmd_t       cmd
);
  import cfla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cfla_dp.sv
// Datapath of the allocator: counters, free-list head, link memory, config and result register.
// Depends on cfla_pkg and cfla_ram.
`default_nettype none

module cfla_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cfla_pkg::cfla_cmd_t             cmd,
  output cfla_pkg::cfla_sts_t                  sts,
  input  wire logic [cfla_pkg::OP_W-1:0]       in_operation,
  input  wire logic [cfla_pkg::IDX_W-1:0]      in_chunk_index,
  input  wire logic                            cfg_we,
  input  wire logic [cfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfla_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_ok,
  output logic      [cfla_pkg::IDX_W-1:0]      out_chunk_given,
  output logic      [cfla_pkg::CNT_W-1:0]      out_free_count,
  output logic      [cfla_pkg::CNT_W-1:0]      out_used_count,
  output logic      [cfla_pkg::TOTAL_W-1:0]    out_total_bytes
);
  import cfla_pkg::*;

  localparam logic [CNT_W-1:0] SPACE = CNT_W'(INDEX_SPACE);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration registers.
  logic [CNT_W-1:0]   cpb_r;
  logic [CNT_W-1:0]   limit_r;
  logic [BYTES_W-1:0] bytes_r;

  // Allocator state.
  logic [ADDR_W-1:0]  head_r,    head_nxt;
  logic [CNT_W-1:0]   bump_r,    bump_nxt;
  logic [IDX_W-1:0]   pos_r,     pos_nxt;
  logic [CNT_W-1:0]   blocks_r,  blocks_nxt;
  logic [CNT_W-1:0]   deleted_r, deleted_nxt;
  logic [TOTAL_W-1:0] total_r,   total_nxt;

  // Captured request.
  logic [OP_W-1:0]    op_r;
  logic [IDX_W-1:0]   idx_r;

  // Result register.
  logic               out_valid_r;
  logic               ok_r, ok_nxt;
  logic [IDX_W-1:0]   given_r, given_nxt;

  // Link memory signals.
  logic               link_we;
  logic [ADDR_W-1:0]  link_rdata;

  // Helpers.
  logic [CNT_W-1:0]   cpb_eff;
  logic [CNT_W-1:0]   pos_inc;
  logic [TOTAL_W:0]   total_sum;
  logic               free_in_range;

  cfla_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (INDEX_SPACE)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (idx_r[ADDR_W-1:0]),
    .wdata (head_r),
    .re    (cmd.load),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r   <= RST_CHUNKS_PER_BLOCK;
      limit_r <= RST_BLOCK_LIMIT;
      bytes_r <= RST_BLOCK_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNKS_PER_BLOCK: cpb_r   <= cfg_data[CNT_W-1:0];
        CFG_BLOCK_LIMIT:      limit_r <= cfg_data[CNT_W-1:0];
        CFG_BLOCK_BYTES:      bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      idx_r <= in_chunk_index;
    end
  end

  assign cpb_eff       = (cpb_r == '0) ? CNT_W'(1) : cpb_r;
  assign pos_inc       = CNT_W'(pos_r) + CNT_W'(1);
  assign total_sum     = {1'b0, total_r} + (TOTAL_W + 1)'(bytes_r);
  assign free_in_range = ({1'b0, idx_r} < SPACE);

  // Operation execution.
  always_comb begin
    head_nxt    = head_r;
    bump_nxt    = bump_r;
    pos_nxt     = pos_r;
    blocks_nxt  = blocks_r;
    deleted_nxt = deleted_r;
    total_nxt   = total_r;
    ok_nxt      = 1'b1;
    given_nxt   = '0;
    link_we     = 1'b0;
    case (op_r)
      OP_ALLOC: begin
        if (deleted_r != '0) begin
          // Pop the head of the free list.
          given_nxt   = IDX_W'(head_r);
          head_nxt    = link_rdata;
          deleted_nxt = deleted_r - CNT_W'(1);
        end else if (bump_r >= SPACE) begin
          ok_nxt = 1'b0;
        end else if (pos_r == '0 && blocks_r >= limit_r) begin
          ok_nxt = 1'b0;
        end else begin
          // Bump allocation, taking a new block at a block boundary.
          if (pos_r == '0) begin
            blocks_nxt = blocks_r + CNT_W'(1);
            total_nxt  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          end
          given_nxt = bump_r[IDX_W-1:0];
          bump_nxt  = bump_r + CNT_W'(1);
          pos_nxt   = (pos_inc >= cpb_eff) ? '0 : pos_inc[IDX_W-1:0];
        end
      end
      OP_FREE: begin
        if (free_in_range) begin
          link_we     = cmd.commit;
          head_nxt    = idx_r[ADDR_W-1:0];
          deleted_nxt = (deleted_r != CNT_MAX) ? deleted_r + CNT_W'(1) : deleted_r;
        end
      end
      OP_CLEAR: begin
        head_nxt    = '0;
        bump_nxt    = '0;
        pos_nxt     = '0;
        blocks_nxt  = '0;
        deleted_nxt = '0;
        total_nxt   = '0;
      end
      default: ;
    endcase
  end

  // State update at commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      bump_r    <= '0;
      pos_r     <= '0;
      blocks_r  <= '0;
      deleted_r <= '0;
      total_r   <= '0;
    end else if (cmd.commit) begin
      head_r    <= head_nxt;
      bump_r    <= bump_nxt;
      pos_r     <= pos_nxt;
      blocks_r  <= blocks_nxt;
      deleted_r <= deleted_nxt;
      total_r   <= total_nxt;
    end
  end

  // Result register; a new result may land in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r            <= ok_nxt;
      given_r         <= given_nxt;
      out_free_count  <= deleted_nxt;
      out_used_count  <= bump_nxt;
      out_total_bytes <= total_nxt;
    end
  end

  assign sts.slot_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_chunk_given = given_r;

endmodule

`default_nettype wire

>>> hw/rtl/chunk_free_list_allocator_core.sv
// Chunk free-list allocator: allocate, free and clear requests, one result per request.
// An accepted request is captured and its link read started; the result is registered once the
// result slot is free. No new request is taken until the current one has been committed.
// Reset (synchronous, rst_n low): counters, list head and result valid clear; config
// returns to 64 chunks per block, 64 blocks, 4096 bytes. The link memory is not initialized.
`default_nettype none

module chunk_free_list_allocator_core (
  input  wire logic clk,
  input  wire logic rst_n,
  cfla_req_if.sink  in_ch,
  cfla_rsp_if.source out_ch,
  cfla_cfg_if.sink  cfg_ch
);
  import cfla_pkg::*;

  cfla_cmd_t cmd;
  cfla_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  cfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfla_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_chunk_index  (in_ch.chunk_index),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_ok          (out_ch.ok),
    .out_chunk_given (out_ch.chunk_given),
    .out_free_count  (out_ch.free_count),
    .out_used_count  (out_ch.used_count),
    .out_total_bytes (out_ch.total_bytes)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for chunk_free_list_allocator_core: drives allocate, free and clear
// requests, predicts every result in a scoreboard class and compares field by field.
// Depends on cfla_pkg and the channel interfaces in cfla_ifs.
`timescale 1ns / 100ps

module testbench;
  import cfla_pkg::*;

  // Operation code that the block must treat as a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic               ok;
    logic [IDX_W-1:0]   chunk_given;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   used_count;
    logic [TOTAL_W-1:0] total_bytes;
  } alloc_result_t;

  // Scoreboard: mirrors the allocator state and keeps the results still owed by the block.
  class chunk_ledger;
    logic [CNT_W-1:0]   per_block  = RST_CHUNKS_PER_BLOCK;
    logic [CNT_W-1:0]   limit      = RST_BLOCK_LIMIT;
    logic [BYTES_W-1:0] unit_bytes = RST_BLOCK_BYTES;

    logic [IDX_W-1:0]   head = '0;
    logic               list_nonempty = 1'b0;
    logic [IDX_W-1:0]   link [INDEX_SPACE];
    bit                 link_written [INDEX_SPACE];
    logic [CNT_W-1:0]   bump = '0;
    logic [IDX_W-1:0]   position = '0;
    logic [CNT_W-1:0]   obtained = '0;
    logic [CNT_W-1:0]   free_depth = '0;
    logic [TOTAL_W-1:0] total = '0;

    alloc_result_t owed_results[$];
    int failures = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHUNKS_PER_BLOCK: per_block = data[CNT_W-1:0];
        CFG_BLOCK_LIMIT:      limit = data[CNT_W-1:0];
        CFG_BLOCK_BYTES:      unit_bytes = data[BYTES_W-1:0];
        default: ;
      endcase
    endfunction

    // True when the next allocation would follow a link that was never written.
    function bit pop_hits_unwritten_link();
      return list_nonempty && free_depth != 0 && !link_written[head];
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function alloc_result_t note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
      alloc_result_t      r;
      logic [CNT_W-1:0]   span;
      logic [TOTAL_W:0]   sum;
      int                 nxt;
      r = '0;
      r.ok = 1'b1;
      case (op)
        OP_ALLOC: begin
          span = (per_block == 0) ? 13'd1 : per_block;
          if (list_nonempty && free_depth != 0) begin
            // Pop the head of the free list.
            r.chunk_given = head;
            head = link[head];
            free_depth = free_depth - CNT_W'(1);
            list_nonempty = (free_depth != 0);
          end else if (bump >= INDEX_SPACE) begin
            r.ok = 1'b0;
          end else if (position == 0 && obtained >= limit) begin
            r.ok = 1'b0;
          end else begin
            // Bump allocation, taking a new block at a block boundary.
            if (position == 0) begin
              obtained = obtained + CNT_W'(1);
              sum = {1'b0, total} + {{(TOTAL_W + 1 - BYTES_W){1'b0}}, unit_bytes};
              total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
            r.chunk_given = bump[IDX_W-1:0];
            bump = bump + CNT_W'(1);
            nxt = int'(position) + 1;
            position = (nxt >= int'(span)) ? '0 : nxt[IDX_W-1:0];
          end
        end
        OP_FREE: begin
          if (idx < INDEX_SPACE) begin
            link[idx] = head;
            link_written[idx] = 1'b1;
            head = idx;
            list_nonempty = 1'b1;
            if (free_depth != '1) free_depth = free_depth + CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          head = '0;
          list_nonempty = 1'b0;
          bump = '0;
          position = '0;
          obtained = '0;
          free_depth = '0;
          total = '0;
        end
        default: ;
      endcase
      r.free_count = free_depth;
      r.used_count = bump;
      r.total_bytes = total;
      owed_results.push_back(r);
      return r;
    endfunction

    // Compares one delivered result with the oldest owed result.
    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result: ok %0d chunk_given %0d", got.ok, got.chunk_given);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        failures++;
      end
      if (got.chunk_given !== want.chunk_given) begin
        $error("chunk_given: expected %0d, got %0d", want.chunk_given, got.chunk_given);
        failures++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
        failures++;
      end
      if (got.used_count !== want.used_count) begin
        $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
        failures++;
      end
      if (got.total_bytes !== want.total_bytes) begin
        $error("total_bytes: expected %0d, got %0d", want.total_bytes, got.total_bytes);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cfla_req_if in_ch();
  cfla_rsp_if out_ch();
  cfla_cfg_if cfg_ch();

  chunk_free_list_allocator_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  chunk_ledger ledger = new();
  logic [IDX_W-1:0] live_chunks[$];
  int  results_seen = 0;
  bit  quiet_run = 1'b0;

  // Clock: 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result monitor: every delivered result is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      ledger.check_result({out_ch.ok, out_ch.chunk_given, out_ch.free_count,
                           out_ch.used_count, out_ch.total_bytes});
    end
  end

  // Result receiver: random short stalls, plus two long hold-offs so the block backs up.
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= 300 + 500 * holds_done) begin
        out_ch.ready <= 1'b0;
        holds_done++;
        repeat (60) @(posedge clk);
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Sends one request, with an optional idle burst first. Valid stays high on return.
  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    alloc_result_t predicted;
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.chunk_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = ledger.note_request(op, idx);
    if (op == OP_ALLOC && predicted.ok) live_chunks.push_back(predicted.chunk_given);
    if (op == OP_CLEAR) live_chunks.delete();
  endtask

  // One random request: mostly allocations and frees of live chunks, some noise.
  task automatic random_request();
    int unsigned pick;
    int unsigned pos;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    idx = IDX_W'($urandom_range(0, 4095));
    if (pick < 50) op = OP_ALLOC;
    else if (pick < 94) op = OP_FREE;
    else if (pick < 97) op = OP_CLEAR;
    else op = OP_UNUSED;
    if (op == OP_FREE && live_chunks.size() != 0 && $urandom_range(0, 9) < 8) begin
      pos = $urandom_range(0, live_chunks.size() - 1);
      idx = live_chunks[pos];
      live_chunks.delete(pos);
    end
    // Never make the block follow a link that was never written.
    if (op == OP_ALLOC && ledger.pop_hits_unwritten_link()) op = OP_FREE;
    issue(op, idx);
  endtask

  // Waits until every owed result has arrived and the block has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    ledger.set_register(idx, data);
  endtask

  // Writes all three registers while the block is idle.
  task automatic configure(input logic [CFG_DATA_W-1:0] per_block,
                           input logic [CFG_DATA_W-1:0] limit,
                           input logic [CFG_DATA_W-1:0] unit_bytes);
    drain();
    cfg_put(CFG_CHUNKS_PER_BLOCK, per_block);
    cfg_put(CFG_BLOCK_LIMIT, limit);
    cfg_put(CFG_BLOCK_BYTES, unit_bytes);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Main stimulus.
  initial begin : stimulus
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_ALLOC;
    in_ch.chunk_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_CHUNKS_PER_BLOCK;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset configuration.
    issue(OP_UNUSED, 12'hFFF);
    issue(OP_ALLOC, 12'hFFF);
    issue(OP_ALLOC, 12'h000);
    issue(OP_ALLOC, 12'h555);
    issue(OP_FREE, 12'd2);
    issue(OP_FREE, 12'd0);
    // Freeing the top index, which was never handed out.
    issue(OP_FREE, 12'hFFF);
    issue(OP_ALLOC, 12'hAAA);
    issue(OP_ALLOC, 12'h000);
    issue(OP_ALLOC, 12'h000);
    issue(OP_ALLOC, 12'h000);
    // Double free of the same chunk is accepted without a check.
    issue(OP_FREE, 12'd1);
    issue(OP_FREE, 12'd1);
    issue(OP_ALLOC, 12'h000);
    issue(OP_ALLOC, 12'h000);
    issue(OP_ALLOC, 12'h000);
    issue(OP_CLEAR, 12'hAAA);
    issue(OP_ALLOC, 12'h000);
    issue(OP_UNUSED, 12'h000);

    // Single-chunk blocks and a single block: bump allocation fails quickly.
    configure(32'd1, 32'd1, 32'd1);
    repeat (120) random_request();

    // Zero chunks per block acts as one; a zero block limit fails every block request.
    configure(32'd0, 32'd0, 32'd0);
    repeat (80) random_request();

    configure(32'd3, 32'd5, $urandom);
    repeat (150) random_request();

    configure(32'd4096, 32'd4096, 32'hFFFF_FFFF);
    repeat (150) random_request();

    configure(32'h1FFF, 32'd2, $urandom);
    repeat (100) random_request();

    // One-chunk blocks of the largest size: the byte total saturates.
    configure(32'd1, 32'h1FFF, 32'hFFFF_FFFF);
    issue(OP_CLEAR, 12'h000);
    repeat (260) issue(OP_ALLOC, IDX_W'($urandom_range(0, 4095)));
    repeat (40) random_request();

    // Small random settings, with junk above the register width.
    configure({19'($urandom_range(0, 19'h7FFFF)), 13'($urandom_range(1, 16))},
              {19'($urandom_range(0, 19'h7FFFF)), 13'($urandom_range(1, 20))}, $urandom);
    issue(OP_CLEAR, 12'h000);
    repeat (150) random_request();
    quiet_run = 1'b1;
    repeat (150) random_request();

    drain();
    if (ledger.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cfla_pkg.sv
hw/rtl/cfla_ifs.sv
hw/rtl/cfla_ram.sv
hw/rtl/cfla_ctrl.sv
hw/rtl/cfla_dp.sv
hw/rtl/chunk_free_list_allocator_core.sv
tb/sv/testbench.sv
